// ----- sv/rgb_to_hsv_pixel_assert.svh -----
// assertion macros for the rgb to hsv pixel block
`ifndef RGB_TO_HSV_PIXEL_ASSERT_SVH
`define RGB_TO_HSV_PIXEL_ASSERT_SVH

// same-cycle implication
`define HSV_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rgb_to_hsv_pixel: check failed");

// implication after a fixed number of cycles
`define HSV_ASSERT_DLY(name, ante, dly, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
    else $error("rgb_to_hsv_pixel: latency check failed");

`endif

// ----- sv/rgbhsv_pkg.sv -----
`default_nettype none

package rgbhsv_pkg;

  localparam int PIX_W    = 8;
  localparam int HUE_W    = 15;
  localparam int RECIP_K  = 24;
  localparam int RECIP_W  = RECIP_K + 1;
  localparam int DIV_LAT  = 3;

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_t;

  typedef struct packed {
    sector_t              sector;
    logic                 neg;
    logic                 grey;
    logic                 black;
    logic [PIX_W-1:0]     brightness;
  } side_t;

endpackage

`default_nettype wire

// ----- sv/rgb_to_hsv_pixel.sv -----
// channel   | dir | signals                          | handshake
// ----------+-----+----------------------------------+--------------------------
// pixel in  | in  | red, green, blue                 | start high, busy low
// hsv out   | out | hue, saturation, brightness      | done high for one cycle
//
// one pixel per clock; busy never rises, so a beat can enter on every cycle
// pipeline: input stage, three reciprocal divider stages, output stage
// the divider (lookup, multiply, correct) sets the depth; its correct stage
// holds a multiply, a subtract and a compare
// rst clears the valid bits only; payload registers are not reset
// the receiver cannot stall, so the pipeline never holds

`default_nettype none

module rgb_to_hsv_pixel
  import rgbhsv_pkg::*;
#(
  parameter int HUE_FRAC_BITS = 6
)
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [PIX_W-1:0] red,
  input  wire logic [PIX_W-1:0] green,
  input  wire logic [PIX_W-1:0] blue,
  output logic                  done,
  output logic [HUE_W-1:0]      hue,
  output logic [PIX_W-1:0]      saturation,
  output logic [PIX_W-1:0]      brightness
);

  localparam int SCALE   = 60 << HUE_FRAC_BITS;
  localparam int HNUM_W  = 14 + HUE_FRAC_BITS;
  localparam int SNUM_W  = 2 * PIX_W;
  localparam int HSUM_W  = (9 + HUE_FRAC_BITS > HUE_W) ? 9 + HUE_FRAC_BITS : HUE_W;
  localparam int LATENCY = DIV_LAT + 2;

  assign busy = 1'b0;

  logic             valid_a;
  side_t            side_a;
  logic [PIX_W-1:0] delta_a;
  logic [PIX_W-1:0] dmag_a;

  rgbhsv_front u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .red   (red),
    .green (green),
    .blue  (blue),
    .valid (valid_a),
    .side  (side_a),
    .delta (delta_a),
    .dmag  (dmag_a)
  );

  logic [HNUM_W-1:0] hnum;
  logic [SNUM_W-1:0] snum;
  logic [HNUM_W-1:0] hquo;
  logic [SNUM_W-1:0] squo;

  assign hnum = HNUM_W'(dmag_a) * HNUM_W'(SCALE);
  assign snum = {delta_a, {PIX_W{1'b0}}} - SNUM_W'(delta_a);

  rgbhsv_div #(.NUM_W(HNUM_W)) u_hue_div (
    .clk (clk),
    .num (hnum),
    .den (delta_a),
    .quo (hquo)
  );

  rgbhsv_div #(.NUM_W(SNUM_W)) u_sat_div (
    .clk (clk),
    .num (snum),
    .den (side_a.brightness),
    .quo (squo)
  );

  // sideband and valid bits ride alongside the divider stages
  logic  valid_d [DIV_LAT];
  side_t side_d  [DIV_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_LAT; i++) valid_d[i] <= 1'b0;
    end else begin
      valid_d[0] <= valid_a;
      for (int i = 1; i < DIV_LAT; i++) valid_d[i] <= valid_d[i-1];
    end
  end

  always_ff @(posedge clk) begin
    side_d[0] <= side_a;
    for (int i = 1; i < DIV_LAT; i++) side_d[i] <= side_d[i-1];
  end

  // hue assembly
  side_t             side_e;
  logic [HSUM_W-1:0] frac_e;
  logic [HSUM_W-1:0] offset_e;
  logic [HSUM_W-1:0] hue_next;

  assign side_e = side_d[DIV_LAT-1];
  assign frac_e = HSUM_W'(hquo);

  always_comb begin
    unique case (side_e.sector)
      SECT_RED:   offset_e = side_e.neg ? HSUM_W'(6 * SCALE) : '0;
      SECT_GREEN: offset_e = HSUM_W'(2 * SCALE);
      SECT_BLUE:  offset_e = HSUM_W'(4 * SCALE);
      default:    offset_e = '0;
    endcase
    if (side_e.grey) begin
      hue_next = '0;
    end else if (side_e.neg) begin
      hue_next = offset_e - frac_e;
    end else begin
      hue_next = offset_e + frac_e;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid_d[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    hue        <= hue_next[HUE_W-1:0];
    saturation <= side_e.black ? '0 : squo[PIX_W-1:0];
    brightness <= side_e.brightness;
  end

`include "rgb_to_hsv_pixel_assert.svh"

  `HSV_ASSERT_DLY(a_latency, start, LATENCY, done)
  `HSV_ASSERT_IMP(a_source, done, $past(start, LATENCY))
  `HSV_ASSERT_IMP(a_black, done && brightness == '0, saturation == '0)
  `HSV_ASSERT_IMP(a_grey, done && saturation == '0, hue == '0)

endmodule

`default_nettype wire

// ----- sv/rgbhsv_front.sv -----
`default_nettype none

module rgbhsv_front
  import rgbhsv_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [PIX_W-1:0] red,
  input  wire logic [PIX_W-1:0] green,
  input  wire logic [PIX_W-1:0] blue,
  output logic                  valid,
  output side_t                 side,
  output logic [PIX_W-1:0]      delta,
  output logic [PIX_W-1:0]      dmag
);

  sector_t          sector_next;
  logic [PIX_W-1:0] mx_next;
  logic [PIX_W-1:0] mn_next;
  logic [PIX_W-1:0] op_a;
  logic [PIX_W-1:0] op_b;
  logic             neg_next;

  always_comb begin
    if (red >= green && red >= blue) begin
      sector_next = SECT_RED;
      mx_next     = red;
      op_a        = green;
      op_b        = blue;
    end else if (green >= blue) begin
      sector_next = SECT_GREEN;
      mx_next     = green;
      op_a        = blue;
      op_b        = red;
    end else begin
      sector_next = SECT_BLUE;
      mx_next     = blue;
      op_a        = red;
      op_b        = green;
    end
    mn_next = red;
    if (green < mn_next) mn_next = green;
    if (blue < mn_next) mn_next = blue;
    neg_next = op_a < op_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= start;
    end
  end

  always_ff @(posedge clk) begin
    side.sector     <= sector_next;
    side.neg        <= neg_next;
    side.grey       <= (mx_next == mn_next);
    side.black      <= (mx_next == '0);
    side.brightness <= mx_next;
    delta           <= mx_next - mn_next;
    dmag            <= neg_next ? (op_b - op_a) : (op_a - op_b);
  end

endmodule

`default_nettype wire

// ----- sv/rgbhsv_div.sv -----
`default_nettype none

module rgbhsv_div
  import rgbhsv_pkg::*;
#(
  parameter int NUM_W = 20
)
(
  input  wire logic             clk,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [PIX_W-1:0] den,
  output logic [NUM_W-1:0]      quo
);

  localparam int TAB_N = 1 << PIX_W;

  logic [RECIP_W-1:0] recip_tab [TAB_N];

  for (genvar i = 0; i < TAB_N; i++) begin : g_recip
    localparam longint unsigned RV = (longint'(1) << RECIP_K) / ((i == 0) ? 1 : i);
    assign recip_tab[i] = (i == 0) ? '0 : RECIP_W'(RV);
  end

  // stage 1: reciprocal lookup
  logic [NUM_W-1:0]   num1;
  logic [PIX_W-1:0]   den1;
  logic [RECIP_W-1:0] recip1;

  always_ff @(posedge clk) begin
    num1   <= num;
    den1   <= den;
    recip1 <= recip_tab[den];
  end

  // stage 2: estimate, low by at most one
  logic [NUM_W+RECIP_W-1:0] prod2;
  logic [NUM_W-1:0]         num2;
  logic [PIX_W-1:0]         den2;
  logic [NUM_W-1:0]         est2;

  assign prod2 = (NUM_W+RECIP_W)'(num1) * (NUM_W+RECIP_W)'(recip1);

  always_ff @(posedge clk) begin
    num2 <= num1;
    den2 <= den1;
    est2 <= prod2[RECIP_K +: NUM_W];
  end

  // stage 3: remainder check and correction
  logic [NUM_W+PIX_W-1:0] back3;
  logic [NUM_W+PIX_W-1:0] rem3;

  assign back3 = (NUM_W+PIX_W)'(est2) * (NUM_W+PIX_W)'(den2);
  assign rem3  = (NUM_W+PIX_W)'(num2) - back3;

  always_ff @(posedge clk) begin
    quo <= (rem3 >= (NUM_W+PIX_W)'(den2)) ? est2 + NUM_W'(1) : est2;
  end

endmodule

`default_nettype wire

// ----- dv/tb_rgb_to_hsv_pixel.sv -----
`timescale 1ns / 1ps

module tb_rgb_to_hsv_pixel;
  import rgbhsv_pkg::*;

  localparam int HUE_FRAC_BITS = 6;
  localparam int SECTOR_SCALE = 60 << HUE_FRAC_BITS;
  localparam int PIPE_LAT = 5;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [PIX_W-1:0] sat;
    logic [PIX_W-1:0] bright;
  } hsv_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [PIX_W-1:0] red = '0;
  logic [PIX_W-1:0] green = '0;
  logic [PIX_W-1:0] blue = '0;
  logic busy;
  logic done;
  logic [HUE_W-1:0] hue;
  logic [PIX_W-1:0] saturation;
  logic [PIX_W-1:0] brightness;

  hsv_t hsv_expected_q[$];
  int errors = 0;
  int idle_pct = 0;

  rgb_to_hsv_pixel #(.HUE_FRAC_BITS(HUE_FRAC_BITS)) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .red(red),
    .green(green),
    .blue(blue),
    .done(done),
    .hue(hue),
    .saturation(saturation),
    .brightness(brightness)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

  function automatic hsv_t predict_hsv(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                                       logic [PIX_W-1:0] b);
    int ri, gi, bi, mx, mn, delta, h;
    sector_t sect;
    hsv_t res;
    ri = int'(r);
    gi = int'(g);
    bi = int'(b);
    // ties go to red, then green
    mx = ri;
    sect = SECT_RED;
    if (gi > mx) begin
      mx = gi;
      sect = SECT_GREEN;
    end
    if (bi > mx) begin
      mx = bi;
      sect = SECT_BLUE;
    end
    mn = ri;
    if (gi < mn) mn = gi;
    if (bi < mn) mn = bi;
    delta = mx - mn;
    if (delta == 0) begin
      h = 0;
    end else begin
      case (sect)
        SECT_RED: begin
          h = (gi - bi) * SECTOR_SCALE / delta;
          if (h < 0) h = h + 6 * SECTOR_SCALE;
        end
        SECT_GREEN: h = 2 * SECTOR_SCALE + (bi - ri) * SECTOR_SCALE / delta;
        default: h = 4 * SECTOR_SCALE + (ri - gi) * SECTOR_SCALE / delta;
      endcase
    end
    res.hue = h[HUE_W-1:0];
    res.sat = '0;
    if (mx != 0) res.sat = PIX_W'((delta * 255) / mx);
    res.bright = mx[PIX_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // result check, then capture of the beat accepted at this edge
  always @(posedge clk) begin
    hsv_t want;
    if (!rst) begin
      if (done) begin
        if (hsv_expected_q.size() == 0) begin
          report_mismatch("result with nothing pending, hue", int'(hue), 0);
        end else begin
          want = hsv_expected_q.pop_front();
          if (hue !== want.hue) report_mismatch("hue", int'(hue), int'(want.hue));
          if (saturation !== want.sat)
            report_mismatch("saturation", int'(saturation), int'(want.sat));
          if (brightness !== want.bright)
            report_mismatch("brightness", int'(brightness), int'(want.bright));
        end
      end
      if (start && !busy) hsv_expected_q.push_back(predict_hsv(red, green, blue));
    end
  end

  task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                            input logic [PIX_W-1:0] b);
    red <= r;
    green <= g;
    blue <= b;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic drain_results;
    start <= 1'b0;
    @(posedge clk);
    while (hsv_expected_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT) @(posedge clk);
  endtask

  task automatic test_directed_corners;
    idle_pct = 0;
    send_pixel(0, 0, 0);
    send_pixel(255, 255, 255);
    send_pixel(128, 128, 128);
    send_pixel(1, 1, 1);
    send_pixel(255, 0, 0);
    send_pixel(0, 255, 0);
    send_pixel(0, 0, 255);
    send_pixel(255, 255, 0);
    send_pixel(0, 255, 255);
    send_pixel(255, 0, 255);
    send_pixel(255, 0, 1);
    send_pixel(255, 1, 0);
    send_pixel(254, 0, 255);
    send_pixel(1, 0, 0);
    send_pixel(0, 1, 0);
    send_pixel(0, 0, 1);
    send_pixel(1, 0, 1);
    send_pixel(255, 254, 253);
    send_pixel(200, 100, 50);
    send_pixel(50, 200, 100);
    send_pixel(100, 50, 200);
    send_pixel(255, 128, 0);
    send_pixel(128, 255, 254);
    // hold off until the pipe is empty
    drain_results();
  endtask

  task automatic test_ties_and_grey(input int n, input int pct);
    int v, a, b;
    idle_pct = pct;
    repeat (n) begin
      v = $urandom_range(255);
      a = $urandom_range(255);
      case ($urandom_range(3))
        0: send_pixel(PIX_W'(v), PIX_W'(v), PIX_W'(a));
        1: send_pixel(PIX_W'(a), PIX_W'(v), PIX_W'(v));
        2: send_pixel(PIX_W'(v), PIX_W'(a), PIX_W'(v));
        default: begin
          // near grey, tiny delta
          a = v + $urandom_range(2) - 1;
          b = v + $urandom_range(2) - 1;
          if (a < 0) a = 0;
          if (a > 255) a = 255;
          if (b < 0) b = 0;
          if (b > 255) b = 255;
          send_pixel(PIX_W'(v), PIX_W'(a), PIX_W'(b));
        end
      endcase
    end
  endtask

  task automatic test_random_stream(input int n, input int pct);
    int sel;
    logic [PIX_W-1:0] r, g, b;
    idle_pct = pct;
    repeat (n) begin
      sel = $urandom_range(99);
      r = PIX_W'($urandom_range(255));
      g = PIX_W'($urandom_range(255));
      b = PIX_W'($urandom_range(255));
      if (sel < 15) begin
        case ($urandom_range(2))
          0: r = g;
          1: g = b;
          default: b = r;
        endcase
      end else if (sel < 25) begin
        r = $urandom_range(1) ? 8'd255 : 8'd0;
        b = $urandom_range(1) ? 8'd255 : 8'd0;
      end else if (sel < 32) begin
        r = PIX_W'($urandom_range(3));
        g = PIX_W'($urandom_range(3));
        b = PIX_W'($urandom_range(3));
      end
      send_pixel(r, g, b);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed_corners();
    test_random_stream(350, 0);
    test_random_stream(330, 87);
    test_random_stream(300, 24);
    test_ties_and_grey(80, 87);
    test_ties_and_grey(40, 0);
    drain_results();
    repeat (PIPE_LAT * 2) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
